FILE: src/sprc_pkg.sv
// ----------------------------------------------------------------------------
// sprc_pkg: shared types and constants of the stepper pulse ramp controller
// Item layouts, opcodes, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package sprc_pkg;

   localparam int FREQ_BITS  = 16;
   localparam int COUNT_BITS = 32;
   localparam int CLK_BITS   = 24;
   localparam int CMP_BITS   = CLK_BITS - 1;
   localparam int CSR_BITS   = 24;
   localparam int CSR_IDX_BITS = 2;

   // Opcodes of the input item
   localparam logic [3:0] OP_TICK       = 4'd0;
   localparam logic [3:0] OP_SET_SPEED  = 4'd1;
   localparam logic [3:0] OP_START      = 4'd2;
   localparam logic [3:0] OP_STOP       = 4'd3;
   localparam logic [3:0] OP_SET_DIR    = 4'd4;
   localparam logic [3:0] OP_TOGGLE_DIR = 4'd5;
   localparam logic [3:0] OP_SET_TARGET = 4'd6;
   localparam logic [3:0] OP_CLEAR_CNT  = 4'd7;
   localparam logic [3:0] OP_READ_REACH = 4'd8;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_HZ    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_HZ    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_RAMP_STEP = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLOCK_HZ  = 2'd3;

   // Reset values
   localparam logic [FREQ_BITS-1:0]  RST_MIN_HZ     = 16'd500;
   localparam logic [FREQ_BITS-1:0]  RST_MAX_HZ     = 16'd3000;
   localparam logic [FREQ_BITS-1:0]  RST_RAMP_STEP  = 16'd1;
   localparam logic [CLK_BITS-1:0]   RST_CLOCK_HZ   = 24'd100000;
   localparam logic [FREQ_BITS-1:0]  RST_FREQ       = 16'd1000;
   localparam logic [COUNT_BITS-1:0] RST_PULSE_GOAL = 32'd10000000;

   typedef struct packed {
      logic [3:0]            op;
      logic [FREQ_BITS-1:0]  speed_request_hz;
      logic                  dir_request;
      logic [COUNT_BITS-1:0] pulse_target;
   } sprc_req_type;

   typedef struct packed {
      logic                  pwm_enabled;
      logic                  direction;
      logic                  running;
      logic                  ramping;
      logic [FREQ_BITS-1:0]  active_hz;
      logic [CLK_BITS-1:0]   period_reload;
      logic [CMP_BITS-1:0]   compare_value;
      logic [COUNT_BITS-1:0] pulse_count;
      logic                  reached_flag;
      logic                  reached_event;
      logic                  read_reached;
   } sprc_rsp_type;

   // Divider status toward the controller
   typedef struct packed {
      logic busy;
      logic done;
   } sprc_div_stat_type;

endpackage

FILE: src/stepper_pulse_ramp_controller.sv
// ----------------------------------------------------------------------------
// stepper_pulse_ramp_controller: stepper pulse rate and linear ramp control
// Applies commands and pulse ticks to the motion state, then derives the
// timer reload and compare values through a bit-serial divider.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  request  | req_valid req_ready req_data   | one command or tick item
//  response | rsp_valid rsp_ready rsp_data   | one status item per request
//  csr      | csr_write_en csr_index csr_wdata | register write, no wait
//
//  An item runs from acceptance to a loaded response as follows: the motion
//  state updates at the accepting edge, then the divider start is
//  registered, the divider runs 24 steps (one quotient bit each), the done
//  flag moves the sequencer to load, and the load state fills the response
//  register. The next item is taken once the sequencer is back in idle.
//  Reset restores the register and state defaults at once; no sweep.
//  A held response does not block the next request, but a finished result
//  waits in the load state until the response register is free.
//
module stepper_pulse_ramp_controller
   import sprc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sprc_req_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sprc_rsp_type            rsp_data,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [FREQ_BITS-1:0] min_hz_ff, max_hz_ff, step_hz_ff;
   logic [CLK_BITS-1:0]  clock_hz_ff;

   // Motion state
   logic                  run_ff, run_in;
   logic                  ramp_ff, ramp_in;
   logic                  stop_ff, stop_in;
   logic                  pwm_ff, pwm_in;
   logic                  dir_ff, dir_in;
   logic [FREQ_BITS-1:0]  freq_ff, freq_in;
   logic [FREQ_BITS-1:0]  goal_ff, goal_in;
   logic [FREQ_BITS-1:0]  user_ff, user_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] target_ff, target_in;
   logic                  reached_ff, reached_in;
   logic                  event_ff, event_in;
   logic                  readv_ff, readv_in;

   logic                  div_start_ff, div_start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sprc_rsp_type          rsp_data_ff, rsp_data_in;

   sprc_div_stat_type     div_stat;
   logic [CLK_BITS-1:0]   div_quo;

   logic                  accept;
   logic                  rsp_free;
   logic [FREQ_BITS-1:0]  bounded_hz;
   logic [FREQ_BITS:0]    ramp_up_sum;
   logic [FREQ_BITS-1:0]  ramp_gap;
   logic [FREQ_BITS-1:0]  ramp_freq;
   logic [COUNT_BITS-1:0] count_inc;
   logic [CLK_BITS-1:0]   quo_eff;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Clamp a speed request; if the bounds cross, below min gets min, others get max
   always_comb begin
      if (req_data.speed_request_hz < min_hz_ff) begin
         bounded_hz = min_hz_ff;
      end else if (req_data.speed_request_hz > max_hz_ff) begin
         bounded_hz = max_hz_ff;
      end else begin
         bounded_hz = req_data.speed_request_hz;
      end
   end

   // One ramp step toward the goal, never past it
   assign ramp_up_sum = {1'b0, freq_ff} + {1'b0, step_hz_ff};
   assign ramp_gap    = freq_ff - goal_ff;
   always_comb begin
      if (freq_ff < goal_ff) begin
         if (ramp_up_sum > {1'b0, goal_ff}) begin
            ramp_freq = goal_ff;
         end else begin
            ramp_freq = ramp_up_sum[FREQ_BITS-1:0];
         end
      end else if (freq_ff > goal_ff) begin
         if (ramp_gap < step_hz_ff) begin
            ramp_freq = goal_ff;
         end else begin
            ramp_freq = freq_ff - step_hz_ff;
         end
      end else begin
         ramp_freq = freq_ff;
      end
   end

   assign count_inc = count_ff + 1'b1;

   // Apply one accepted item to the motion state
   always_comb begin
      run_in     = run_ff;
      ramp_in    = ramp_ff;
      stop_in    = stop_ff;
      pwm_in     = pwm_ff;
      dir_in     = dir_ff;
      freq_in    = freq_ff;
      goal_in    = goal_ff;
      user_in    = user_ff;
      count_in   = count_ff;
      target_in  = target_ff;
      reached_in = reached_ff;
      event_in   = event_ff;
      readv_in   = readv_ff;
      if (accept) begin
         event_in = 1'b0;
         readv_in = 1'b0;
         case (req_data.op)
            OP_TICK: begin
               if (run_ff) begin
                  count_in = count_inc;
                  if (ramp_ff) begin
                     freq_in = ramp_freq;
                     ramp_in = (ramp_freq != goal_ff);
                  end
                  if (!reached_ff && (count_inc >= target_ff)) begin
                     reached_in = 1'b1;
                     event_in   = 1'b1;
                  end
                  // Halt once the ramp-down to the stop frequency is over
                  if (!ramp_in && stop_ff) begin
                     stop_in = 1'b0;
                     run_in  = 1'b0;
                     pwm_in  = 1'b0;
                  end
               end
            end
            OP_SET_SPEED: begin
               user_in = bounded_hz;
               if (run_ff) begin
                  goal_in = bounded_hz;
                  ramp_in = 1'b1;
                  stop_in = 1'b0;
               end else begin
                  freq_in = bounded_hz;
               end
            end
            OP_START: begin
               if (!run_ff) begin
                  run_in  = 1'b1;
                  freq_in = min_hz_ff;
                  goal_in = user_ff;
                  ramp_in = 1'b1;
                  stop_in = 1'b0;
                  pwm_in  = 1'b1;
               end
            end
            OP_STOP: begin
               if (run_ff) begin
                  goal_in = min_hz_ff;
                  ramp_in = 1'b1;
                  stop_in = 1'b1;
                  pwm_in  = 1'b1;
               end else begin
                  pwm_in = 1'b0;
               end
            end
            OP_SET_DIR: begin
               // A new level switches at once and restarts from the low bound
               if (dir_ff != req_data.dir_request) begin
                  dir_in  = req_data.dir_request;
                  run_in  = 1'b1;
                  freq_in = min_hz_ff;
                  goal_in = user_ff;
                  ramp_in = 1'b1;
                  stop_in = 1'b0;
                  pwm_in  = 1'b1;
               end
            end
            OP_TOGGLE_DIR: begin
               dir_in = !dir_ff;
            end
            OP_SET_TARGET: begin
               target_in  = req_data.pulse_target;
               reached_in = 1'b0;
            end
            OP_CLEAR_CNT: begin
               count_in = '0;
            end
            OP_READ_REACH: begin
               readv_in   = reached_ff;
               reached_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: update, divide, load response
   always_comb begin
      state_in     = state_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_CALC;
               div_start_in = 1'b1;
            end
         end
         ST_CALC: begin
            if (div_stat.done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (rsp_free) begin
               state_in                  = ST_IDLE;
               rsp_valid_in              = 1'b1;
               rsp_data_in.pwm_enabled   = pwm_ff;
               rsp_data_in.direction     = dir_ff;
               rsp_data_in.running       = run_ff;
               rsp_data_in.ramping       = ramp_ff;
               rsp_data_in.active_hz     = freq_ff;
               rsp_data_in.period_reload = (quo_eff == '0) ? '0 : quo_eff - 1'b1;
               rsp_data_in.compare_value = quo_eff[CLK_BITS-1:1];
               rsp_data_in.pulse_count   = count_ff;
               rsp_data_in.reached_flag  = reached_ff;
               rsp_data_in.reached_event = event_ff;
               rsp_data_in.read_reached  = readv_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A zero frequency gives a zero quotient
   assign quo_eff = (freq_ff == '0) ? '0 : div_quo;

   sprc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (clock_hz_ff),
      .divisor  (freq_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_hz_ff    <= RST_MIN_HZ;
         max_hz_ff    <= RST_MAX_HZ;
         step_hz_ff   <= RST_RAMP_STEP;
         clock_hz_ff  <= RST_CLOCK_HZ;
         run_ff       <= 1'b0;
         ramp_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         pwm_ff       <= 1'b1;
         dir_ff       <= 1'b1;
         freq_ff      <= RST_FREQ;
         goal_ff      <= RST_FREQ;
         user_ff      <= RST_FREQ;
         count_ff     <= '0;
         target_ff    <= RST_PULSE_GOAL;
         reached_ff   <= 1'b0;
         event_ff     <= 1'b0;
         readv_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               REG_MIN_HZ:    min_hz_ff   <= csr_wdata[FREQ_BITS-1:0];
               REG_MAX_HZ:    max_hz_ff   <= csr_wdata[FREQ_BITS-1:0];
               REG_RAMP_STEP: step_hz_ff  <= csr_wdata[FREQ_BITS-1:0];
               REG_CLOCK_HZ:  clock_hz_ff <= csr_wdata[CLK_BITS-1:0];
               default: begin
               end
            endcase
         end
         run_ff     <= run_in;
         ramp_ff    <= ramp_in;
         stop_ff    <= stop_in;
         pwm_ff     <= pwm_in;
         dir_ff     <= dir_in;
         freq_ff    <= freq_in;
         goal_ff    <= goal_in;
         user_ff    <= user_in;
         count_ff   <= count_in;
         target_ff  <= target_in;
         reached_ff <= reached_in;
         event_ff   <= event_in;
         readv_ff   <= readv_in;
      end
   end

   // Response payload holds without reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // No new item while the divider works on the current one
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !req_ready)
      else $error("request accepted while divider busy");

   // A finished result with a free slot shows up on the response side
   a_load_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && rsp_free) |=> rsp_valid)
      else $error("loaded result missing on response");

   // Ramping and a pending stop only exist while in motion
   a_idle_no_ramp: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> (!ramp_ff && !stop_ff))
      else $error("ramp or stop pending while not running");
`endif

endmodule

FILE: src/sprc_divider.sv
// ----------------------------------------------------------------------------
// sprc_divider: bit-serial restoring divider
// Divides the timer clock by the pulse frequency, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sprc_divider
   import sprc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CLK_BITS-1:0]  dividend,
   input  logic [FREQ_BITS-1:0] divisor,
   output sprc_div_stat_type    stat,
   output logic [CLK_BITS-1:0]  quotient
);

   localparam int CNT_BITS = $clog2(CLK_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CLK_BITS-1:0]  shift_ff, shift_in;
   logic [FREQ_BITS-1:0] rem_ff, rem_in;
   logic [FREQ_BITS:0]   rem_next;
   logic [FREQ_BITS+1:0] trial;

   // Bring down the next dividend bit and try the subtract
   assign rem_next = {rem_ff, shift_ff[CLK_BITS-1]};
   assign trial    = {1'b0, rem_next} - {2'b00, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial[FREQ_BITS+1]) begin
            rem_in   = rem_next[FREQ_BITS-1:0];
            shift_in = {shift_ff[CLK_BITS-2:0], 1'b0};
         end else begin
            rem_in   = trial[FREQ_BITS-1:0];
            shift_in = {shift_ff[CLK_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(CLK_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = shift_ff;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stepper_pulse_ramp_controller
// Drives command and tick items with bursty valid and a stalling receiver,
// predicts every status item from a cycle-free model of the motion state
// and compares each response field by field, across several register
// settings written while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import sprc_pkg::*;

   // Opcodes the block must treat as no-ops
   localparam logic [3:0] OP_RSVD_FIRST = 4'd9;
   localparam logic [3:0] OP_RSVD_LAST  = 4'd15;

   // Cycles to let the divider finish before touching registers
   localparam int SETTLE_CYCLES  = 40;
   // Cycles without any handshake before the run is declared hung
   localparam int WATCHDOG_LIMIT = 1000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   sprc_req_type            req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   sprc_rsp_type            rsp_data;
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0]     csr_wdata = '0;

   stepper_pulse_ramp_controller uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Motion model: registers and state as the block should hold them
   // -------------------------------------------------------------------------
   logic [FREQ_BITS-1:0]  cfg_min_hz, cfg_max_hz, cfg_step_hz;
   logic [CLK_BITS-1:0]   cfg_clock_hz;

   logic                  mot_run, mot_ramp, mot_stop_pend, mot_pwm, mot_dir;
   logic                  mot_reached;
   logic [FREQ_BITS-1:0]  mot_freq, mot_goal_hz, mot_user_hz;
   logic [COUNT_BITS-1:0] mot_pulses, mot_target;

   // Expected status items, oldest first
   sprc_rsp_type expected_status_q[$];

   int mismatches      = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int ticks_sent      = 0;
   int reach_events    = 0;
   int settings_used   = 1;
   int burst_left      = 0;

   function automatic void reset_motion_model();
      cfg_min_hz    = RST_MIN_HZ;
      cfg_max_hz    = RST_MAX_HZ;
      cfg_step_hz   = RST_RAMP_STEP;
      cfg_clock_hz  = RST_CLOCK_HZ;
      mot_run       = 1'b0;
      mot_ramp      = 1'b0;
      mot_stop_pend = 1'b0;
      mot_pwm       = 1'b1;
      mot_dir       = 1'b1;
      mot_freq      = RST_FREQ;
      mot_goal_hz   = RST_FREQ;
      mot_user_hz   = RST_FREQ;
      mot_pulses    = '0;
      mot_target    = RST_PULSE_GOAL;
      mot_reached   = 1'b0;
   endfunction

   // With crossed bounds, a request below min gets min and any other gets max
   function automatic logic [FREQ_BITS-1:0] bound_request(logic [FREQ_BITS-1:0] hz);
      if (hz < cfg_min_hz) return cfg_min_hz;
      if (hz > cfg_max_hz) return cfg_max_hz;
      return hz;
   endfunction

   function automatic void restart_from_min();
      mot_run       = 1'b1;
      mot_freq      = cfg_min_hz;
      mot_goal_hz   = mot_user_hz;
      mot_ramp      = 1'b1;
      mot_stop_pend = 1'b0;
      mot_pwm       = 1'b1;
   endfunction

   // Move one ramp step toward the goal without overshoot
   function automatic void step_toward_goal();
      logic [FREQ_BITS:0] raised;
      if (mot_freq < mot_goal_hz) begin
         raised = {1'b0, mot_freq} + {1'b0, cfg_step_hz};
         mot_freq = (raised > {1'b0, mot_goal_hz}) ? mot_goal_hz : raised[FREQ_BITS-1:0];
      end else if (mot_freq > mot_goal_hz) begin
         if (mot_freq - mot_goal_hz < cfg_step_hz) mot_freq = mot_goal_hz;
         else mot_freq = mot_freq - cfg_step_hz;
      end
      if (mot_freq == mot_goal_hz) mot_ramp = 1'b0;
   endfunction

   // Apply one command or tick to the model and return the status it yields
   function automatic sprc_rsp_type apply_command(sprc_req_type cmd);
      sprc_rsp_type status;
      logic [CLK_BITS-1:0] quo;
      status = '0;
      case (cmd.op)
         OP_TICK: begin
            if (mot_run) begin
               mot_pulses = mot_pulses + 1'b1;
               if (mot_ramp) step_toward_goal();
               if (!mot_reached && mot_pulses >= mot_target) begin
                  mot_reached = 1'b1;
                  status.reached_event = 1'b1;
               end
               if (!mot_ramp && mot_stop_pend) begin
                  mot_stop_pend = 1'b0;
                  mot_run       = 1'b0;
                  mot_pwm       = 1'b0;
               end
            end
         end
         OP_SET_SPEED: begin
            mot_user_hz = bound_request(cmd.speed_request_hz);
            if (mot_run) begin
               mot_goal_hz   = mot_user_hz;
               mot_ramp      = 1'b1;
               mot_stop_pend = 1'b0;
            end else begin
               mot_freq = mot_user_hz;
            end
         end
         OP_START: begin
            if (!mot_run) restart_from_min();
         end
         OP_STOP: begin
            if (mot_run) begin
               mot_goal_hz   = cfg_min_hz;
               mot_ramp      = 1'b1;
               mot_stop_pend = 1'b1;
               mot_pwm       = 1'b1;
            end else begin
               mot_pwm = 1'b0;
            end
         end
         OP_SET_DIR: begin
            if (mot_dir != cmd.dir_request) begin
               mot_dir = cmd.dir_request;
               restart_from_min();
            end
         end
         OP_TOGGLE_DIR: mot_dir = !mot_dir;
         OP_SET_TARGET: begin
            mot_target  = cmd.pulse_target;
            mot_reached = 1'b0;
         end
         OP_CLEAR_CNT: mot_pulses = '0;
         OP_READ_REACH: begin
            status.read_reached = mot_reached;
            mot_reached = 1'b0;
         end
         default: ;
      endcase
      quo = (mot_freq == '0) ? '0 : cfg_clock_hz / mot_freq;
      status.pwm_enabled   = mot_pwm;
      status.direction     = mot_dir;
      status.running       = mot_run;
      status.ramping       = mot_ramp;
      status.active_hz     = mot_freq;
      status.period_reload = (quo == '0) ? '0 : quo - 1'b1;
      status.compare_value = quo[CLK_BITS-1:1];
      status.pulse_count   = mot_pulses;
      status.reached_flag  = mot_reached;
      return status;
   endfunction

   // -------------------------------------------------------------------------
   // Request side: bursts of back-to-back items separated by random gaps
   // -------------------------------------------------------------------------
   function automatic sprc_req_type make_item(logic [3:0] op, logic [FREQ_BITS-1:0] hz,
                                              logic dir, logic [COUNT_BITS-1:0] goal);
      sprc_req_type item;
      item.op               = op;
      item.speed_request_hz = hz;
      item.dir_request      = dir;
      item.pulse_target     = goal;
      return item;
   endfunction

   task automatic send_item(input sprc_req_type item);
      sprc_rsp_type status;
      // Drop valid for a gap only between bursts; keep it high inside one
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // Predict at the accepting edge so the model sees items in order
      status = apply_command(item);
      expected_status_q.push_back(status);
      items_sent++;
      if (item.op == OP_TICK) ticks_sent++;
      if (status.reached_event) reach_events++;
   endtask

   task automatic send_op(input logic [3:0] op);
      send_item(make_item(op, FREQ_BITS'($urandom), 1'($urandom), COUNT_BITS'($urandom)));
   endtask

   // Send ticks; optionally quit early once the motor has halted
   task automatic send_ticks(input int count, input bit until_halt);
      for (int i = 0; i < count; i++) begin
         if (until_halt && !mot_run) break;
         send_op(OP_TICK);
      end
   endtask

   // Hold valid low and wait until every response is back and the block is quiet
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Register writes, only with the block idle
   // -------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      case (idx)
         REG_MIN_HZ:    cfg_min_hz   = value[FREQ_BITS-1:0];
         REG_MAX_HZ:    cfg_max_hz   = value[FREQ_BITS-1:0];
         REG_RAMP_STEP: cfg_step_hz  = value[FREQ_BITS-1:0];
         REG_CLOCK_HZ:  cfg_clock_hz = value[CLK_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [FREQ_BITS-1:0] lo_hz,
                                 input logic [FREQ_BITS-1:0] hi_hz,
                                 input logic [FREQ_BITS-1:0] step_hz,
                                 input logic [CLK_BITS-1:0] clk_hz);
      drain_results();
      // Put junk above the 16-bit registers; the block must ignore it
      write_reg(REG_MIN_HZ,    {8'($urandom), lo_hz});
      write_reg(REG_MAX_HZ,    {8'($urandom), hi_hz});
      write_reg(REG_RAMP_STEP, {8'($urandom), step_hz});
      write_reg(REG_CLOCK_HZ,  clk_hz);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // -------------------------------------------------------------------------
   // Response side: stall on a pattern of alternating segments
   // -------------------------------------------------------------------------
   int stall_left  = 0;
   int stall_style = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 9);
         stall_left  = (stall_style == 9) ? $urandom_range(20, 40) : $urandom_range(1, 30);
      end else begin
         stall_left--;
      end
      case (stall_style)
         0, 1, 2, 3: rsp_ready <= 1'b1;             // stretch with no stall
         4, 5, 6:    rsp_ready <= 1'($urandom_range(0, 1));
         7, 8:       rsp_ready <= (stall_left % 3) == 0;
         default:    rsp_ready <= 1'b0;             // long stall
      endcase
   end

   // -------------------------------------------------------------------------
   // Response checker: compare each accepted item against the oldest prediction
   // -------------------------------------------------------------------------
   task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      sprc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status_q.size() == 0) begin
            mismatches++;
            $display("%0t: response expected none, got %h", $time, rsp_data);
         end else begin
            want = expected_status_q.pop_front();
            results_checked++;
            check_field("pwm_enabled", 32'(want.pwm_enabled), 32'(rsp_data.pwm_enabled));
            check_field("direction",   32'(want.direction),   32'(rsp_data.direction));
            check_field("running",     32'(want.running),     32'(rsp_data.running));
            check_field("ramping",     32'(want.ramping),     32'(rsp_data.ramping));
            check_field("active_hz",   32'(want.active_hz),   32'(rsp_data.active_hz));
            check_field("period_reload", 32'(want.period_reload),
                        32'(rsp_data.period_reload));
            check_field("compare_value", 32'(want.compare_value),
                        32'(rsp_data.compare_value));
            check_field("pulse_count", want.pulse_count, rsp_data.pulse_count);
            check_field("reached_flag", 32'(want.reached_flag),
                        32'(rsp_data.reached_flag));
            check_field("reached_event", 32'(want.reached_event),
                        32'(rsp_data.reached_event));
            check_field("read_reached", 32'(want.read_reached),
                        32'(rsp_data.read_reached));
         end
      end
   end

   // Watchdog: end the run if no handshake happens for too long
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                     $time, WATCHDOG_LIMIT, expected_status_q.size());
            $display("stepper_pulse_ramp_controller: mismatch");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Commands with the motor idle at reset settings: clamping, idle stop,
   // direction handling, target and count registers, unused opcodes
   task automatic test_idle_commands();
      send_item(make_item(OP_RSVD_LAST, '0, 1'b0, '0));
      send_item(make_item(OP_RSVD_FIRST, '1, 1'b1, '1));
      send_item(make_item(OP_SET_SPEED, 16'h0000, 1'b0, '0));       // clamps up to min
      send_item(make_item(OP_SET_SPEED, 16'hFFFF, 1'b1, '1));       // clamps down to max
      send_item(make_item(OP_STOP, '0, 1'b0, '0));                  // idle stop drops pwm
      send_item(make_item(OP_TOGGLE_DIR, '1, 1'b1, '1));
      send_item(make_item(OP_SET_DIR, '0, 1'b0, '0));               // same level: no change
      send_item(make_item(OP_SET_TARGET, '0, 1'b0, 32'hFFFF_FFFF));
      send_item(make_item(OP_READ_REACH, '1, 1'b1, '1));
      send_item(make_item(OP_CLEAR_CNT, '0, 1'b0, '0));
   endtask

   // Ramp up from min, retarget while running, stop with ramp-down, restart
   task automatic test_ramp_and_stop();
      write_settings(16'd100, 16'hFFFF, 16'd700, RST_CLOCK_HZ);
      send_item(make_item(OP_SET_DIR, '0, 1'b1, '0));               // new level restarts
      send_ticks(2, 1'b0);
      send_item(make_item(OP_START, '0, 1'b0, '0));                 // ignored while running
      send_item(make_item(OP_SET_SPEED, 16'hFFFF, 1'b0, '0));
      send_ticks(1, 1'b0);
      send_item(make_item(OP_STOP, '0, 1'b0, '0));
      send_ticks(8, 1'b1);                                          // ramp down, then halt
      send_item(make_item(OP_START, '0, 1'b0, '0));
   endtask

   // Sticky reached flag: event only on the first crossing, cleared by read
   task automatic test_pulse_target();
      send_item(make_item(OP_CLEAR_CNT, '0, 1'b0, '0));
      send_item(make_item(OP_SET_TARGET, '0, 1'b0, 32'd2));
      send_ticks(3, 1'b0);
      send_item(make_item(OP_READ_REACH, '0, 1'b0, '0));
   endtask

   // Zero step freezes the ramp; zero frequency and a tiny timer clock give
   // a zero quotient, and the reload must saturate rather than wrap
   task automatic test_zero_rate();
      write_settings(16'd0, 16'd0, 16'd0, 24'd1);
      send_ticks(1, 1'b0);
      send_item(make_item(OP_SET_SPEED, 16'd5, 1'b0, '0));
      send_ticks(1, 1'b0);
      send_item(make_item(OP_SET_DIR, '0, !mot_dir, '0));
      send_item(make_item(OP_STOP, '0, 1'b0, '0));
      send_ticks(2, 1'b1);
   endtask

   // Random traffic: mostly well-formed motion runs with random content,
   // plus target chases, direction flips and raw noise
   task automatic run_traffic(input int quota);
      int first;
      first = items_sent;
      while (items_sent - first < quota) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if ($urandom_range(0, 1)) begin
                  send_item(make_item(OP_SET_SPEED, FREQ_BITS'($urandom), 1'($urandom),
                                      COUNT_BITS'($urandom)));
               end
               if ($urandom_range(0, 3) == 0) begin
                  send_item(make_item(OP_SET_DIR, FREQ_BITS'($urandom), !mot_dir,
                                      COUNT_BITS'($urandom)));
               end
               else send_op(OP_START);
               send_ticks($urandom_range(2, 20), 1'b0);
               if ($urandom_range(0, 1)) begin
                  send_item(make_item(OP_SET_SPEED, FREQ_BITS'($urandom), 1'($urandom),
                                      COUNT_BITS'($urandom)));
                  send_ticks($urandom_range(1, 10), 1'b0);
               end
               send_op(OP_STOP);
               send_ticks($urandom_range(1, 30), 1'b1);
            end
            4, 5: begin
               if ($urandom_range(0, 2) == 0) send_op(OP_CLEAR_CNT);
               send_item(make_item(OP_SET_TARGET, FREQ_BITS'($urandom), 1'($urandom),
                                   mot_pulses + $urandom_range(0, 8)));
               if (!mot_run) send_op(OP_START);
               send_ticks($urandom_range(1, 12), 1'b0);
               send_op(OP_READ_REACH);
            end
            6: begin
               send_item(make_item(OP_SET_DIR, FREQ_BITS'($urandom), 1'($urandom),
                                   COUNT_BITS'($urandom)));
               if ($urandom_range(0, 1)) send_op(OP_TOGGLE_DIR);
               send_ticks($urandom_range(1, 6), 1'b0);
            end
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(0, 2) == 0) send_op(OP_TICK);
                  else send_op(4'($urandom_range(OP_TICK, OP_RSVD_LAST)));
               end
            end
         endcase
      end
   endtask

   task automatic test_random_traffic();
      logic [FREQ_BITS-1:0] lo_hz;
      // Extremes: widest range, largest step, largest timer clock
      write_settings(16'd1, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
      run_traffic(110);
      // Crossed bounds: min above max
      write_settings(16'd4000, 16'd1000, 16'd250, RST_CLOCK_HZ);
      run_traffic(110);
      write_settings(RST_MIN_HZ, RST_MAX_HZ, 16'd40, RST_CLOCK_HZ);
      run_traffic(110);
      repeat (2) begin
         lo_hz = FREQ_BITS'($urandom_range(1, 3000));
         write_settings(lo_hz, FREQ_BITS'($urandom_range(lo_hz, 65535)),
                        FREQ_BITS'($urandom_range(1, 2000)),
                        CLK_BITS'($urandom_range(1, 24'hFF_FFFF)));
         run_traffic(110);
      end
      write_settings(FREQ_BITS'($urandom_range(1, 65535)), FREQ_BITS'($urandom_range(1, 65535)),
                     FREQ_BITS'($urandom_range(1, 65535)),
                     CLK_BITS'($urandom_range(1, 24'hFF_FFFF)));
      run_traffic(110);
   endtask

   // -------------------------------------------------------------------------
   // Sequence: reset once, run each test in turn, drain, report
   // -------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      reset_motion_model();

      test_idle_commands();
      test_ramp_and_stop();
      test_pulse_target();
      test_zero_rate();
      test_random_traffic();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d ticks) over %0d register settings; checked %0d responses.",
               items_sent, ticks_sent, settings_used, results_checked);
      $display("Saw %0d reached events; %0d field mismatches.", reach_events, mismatches);
      if (mismatches == 0 && expected_status_q.size() == 0) begin
         $display("stepper_pulse_ramp_controller: match");
      end else begin
         $display("stepper_pulse_ramp_controller: mismatch");
      end
      $finish;
   end

endmodule
